// ===== sv/cftb_pkg.sv =====
// ----------------------------------------------------------------------------
// cftb_pkg
// Shared types, constants and the control store of the cumulative
// frequency table builder.
// ----------------------------------------------------------------------------
package cftb_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int COUNT_BITS    = 32;
	localparam int DATA_BITS     = 32;
	localparam int LIMIT_BITS    = 32;
	localparam int LAST_BITS     = 8;
	localparam int SUM_BITS      = 41;
	localparam int SHIFT_BITS    = $clog2(SUM_BITS + 1);
	localparam int CFG_IDX_BITS  = 8;
	localparam int STEP_BITS     = 5;

	typedef logic [IDX_BITS-1:0]     idx_t;
	typedef logic [COUNT_BITS-1:0]   count_t;
	typedef logic [DATA_BITS-1:0]    data_t;
	typedef logic [LIMIT_BITS-1:0]   limit_t;
	typedef logic [LAST_BITS-1:0]    last_t;
	typedef logic [SUM_BITS-1:0]     sum_t;
	typedef logic [SHIFT_BITS-1:0]   shift_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [STEP_BITS-1:0]    step_t;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_BUILD = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_INDEX   = 2'd1,
		ST_UNREACHABLE = 2'd2
	} status_t;

	localparam cfg_idx_t REG_LAST_INDEX    = 8'd0;
	localparam cfg_idx_t REG_QUARTER_LIMIT = 8'd1;

	localparam last_t  LAST_INDEX_RESET    = 8'd255;
	localparam limit_t QUARTER_LIMIT_RESET = 32'd16384;

	// datapath operations
	typedef enum logic [3:0] {
		U_NOP,
		U_LATCH,
		U_WR_AMT,
		U_RD_SLOT,
		U_ADD_WB,
		U_RES_RDATA,
		U_SUM_INIT,
		U_RD_IDX,
		U_SUM_ACC,
		U_HALVE,
		U_IDX_CLR,
		U_CUM_WR,
		U_RES_PREV,
		U_RES_ERR1,
		U_RES_ERR2,
		U_EMIT
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_BAD_IDX,
		C_ACTION,
		C_LIMIT_BAD,
		C_IDX_MORE,
		C_FITS,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	typedef struct packed {
		action_t action;
		logic    bad_idx;
		logic    limit_bad;
		logic    idx_more;
		logic    fits;
		logic    out_free;
	} flags_t;

	// program addresses
	localparam step_t S_IDLE      = 5'd0;
	localparam step_t S_CHECK     = 5'd1;
	localparam step_t S_DISPATCH  = 5'd2;
	localparam step_t S_WR        = 5'd3;
	localparam step_t S_ADD_RD    = 5'd4;
	localparam step_t S_ADD_WB    = 5'd5;
	localparam step_t S_RD        = 5'd6;
	localparam step_t S_RD_RES    = 5'd7;
	localparam step_t S_BUILD     = 5'd8;
	localparam step_t S_SUM_RD    = 5'd9;
	localparam step_t S_SUM_ACC   = 5'd10;
	localparam step_t S_SCALE     = 5'd11;
	localparam step_t S_HALVE     = 5'd12;
	localparam step_t S_CUM_INIT  = 5'd13;
	localparam step_t S_CUM_RD    = 5'd14;
	localparam step_t S_CUM_WR    = 5'd15;
	localparam step_t S_BUILD_RES = 5'd16;
	localparam step_t S_ERR1      = 5'd17;
	localparam step_t S_ERR2      = 5'd18;
	localparam step_t S_EMIT      = 5'd19;
	localparam step_t S_RETRY     = 5'd20;

	// control store
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t w;
		w = '{U_NOP, C_ALWAYS, S_IDLE};
		unique case (step)
			S_IDLE:      w = '{U_LATCH,     C_NO_REQ,    S_IDLE};
			S_CHECK:     w = '{U_NOP,       C_BAD_IDX,   S_ERR1};
			S_DISPATCH:  w = '{U_NOP,       C_ACTION,    S_IDLE};
			S_WR:        w = '{U_WR_AMT,    C_ALWAYS,    S_EMIT};
			S_ADD_RD:    w = '{U_RD_SLOT,   C_NEXT,      S_IDLE};
			S_ADD_WB:    w = '{U_ADD_WB,    C_ALWAYS,    S_EMIT};
			S_RD:        w = '{U_RD_SLOT,   C_NEXT,      S_IDLE};
			S_RD_RES:    w = '{U_RES_RDATA, C_ALWAYS,    S_EMIT};
			S_BUILD:     w = '{U_SUM_INIT,  C_LIMIT_BAD, S_ERR2};
			S_SUM_RD:    w = '{U_RD_IDX,    C_NEXT,      S_IDLE};
			S_SUM_ACC:   w = '{U_SUM_ACC,   C_IDX_MORE,  S_SUM_RD};
			S_SCALE:     w = '{U_NOP,       C_FITS,      S_CUM_INIT};
			S_HALVE:     w = '{U_HALVE,     C_ALWAYS,    S_SCALE};
			S_CUM_INIT:  w = '{U_IDX_CLR,   C_NEXT,      S_IDLE};
			S_CUM_RD:    w = '{U_RD_IDX,    C_NEXT,      S_IDLE};
			S_CUM_WR:    w = '{U_CUM_WR,    C_IDX_MORE,  S_CUM_RD};
			S_BUILD_RES: w = '{U_RES_PREV,  C_ALWAYS,    S_EMIT};
			S_ERR1:      w = '{U_RES_ERR1,  C_ALWAYS,    S_EMIT};
			S_ERR2:      w = '{U_RES_ERR2,  C_ALWAYS,    S_EMIT};
			S_EMIT:      w = '{U_EMIT,      C_OUT_FREE,  S_IDLE};
			S_RETRY:     w = '{U_NOP,       C_ALWAYS,    S_EMIT};
			default:     w = '{U_NOP,       C_ALWAYS,    S_IDLE};
		endcase
		return w;
	endfunction

	// jump table for the request's action
	function automatic step_t dispatch(input action_t action);
		step_t s;
		s = S_RD;
		unique case (action)
			ACT_WRITE: s = S_WR;
			ACT_ADD:   s = S_ADD_RD;
			ACT_BUILD: s = S_BUILD;
			ACT_READ:  s = S_RD;
			default:   s = S_RD;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/cftb_if.sv =====
// ----------------------------------------------------------------------------
// cftb channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface cftb_cmd_if;
	logic                 valid;
	logic                 ready;
	cftb_pkg::action_t    action;
	logic [7:0]           slot;
	logic [31:0]          amount;

	modport source(output valid, action, slot, amount, input ready);
	modport sink(input valid, action, slot, amount, output ready);
endinterface

interface cftb_rsp_if;
	logic                 valid;
	logic                 ready;
	cftb_pkg::status_t    status;
	logic [31:0]          data;

	modport source(output valid, status, data, input ready);
	modport sink(input valid, status, data, output ready);
endinterface

interface cftb_cfg_if;
	logic                 valid;
	logic                 ready;
	cftb_pkg::cfg_idx_t   index;
	logic [31:0]          data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/cftb_sequencer.sv =====
// ----------------------------------------------------------------------------
// cftb_sequencer
// Step counter over the control store, with conditional and dispatch jumps.
// ----------------------------------------------------------------------------
module cftb_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  cftb_pkg::flags_t      flags,
	output cftb_pkg::ctrl_word_t  ctrl,
	output logic                  cmd_ready
);

	cftb_pkg::step_t upc_q;
	cftb_pkg::step_t target;
	cftb_pkg::step_t next_step;
	logic            jump;

	assign ctrl      = cftb_pkg::ucode(upc_q);
	assign cmd_ready = (upc_q == cftb_pkg::S_IDLE);

	always_comb begin
		jump = 1'b0;
		unique case (ctrl.cond)
			cftb_pkg::C_NEXT:      jump = 1'b0;
			cftb_pkg::C_ALWAYS:    jump = 1'b1;
			cftb_pkg::C_NO_REQ:    jump = !cmd_valid;
			cftb_pkg::C_BAD_IDX:   jump = flags.bad_idx;
			cftb_pkg::C_ACTION:    jump = 1'b1;
			cftb_pkg::C_LIMIT_BAD: jump = flags.limit_bad;
			cftb_pkg::C_IDX_MORE:  jump = flags.idx_more;
			cftb_pkg::C_FITS:      jump = flags.fits;
			cftb_pkg::C_OUT_FREE:  jump = flags.out_free;
			default:               jump = 1'b0;
		endcase
		target    = (ctrl.cond == cftb_pkg::C_ACTION) ?
		            cftb_pkg::dispatch(flags.action) : ctrl.target;
		next_step = jump ? target : upc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= cftb_pkg::S_IDLE;
		end else begin
			upc_q <= next_step;
		end
	end

endmodule

// ===== sv/cftb_datapath.sv =====
// ----------------------------------------------------------------------------
// cftb_datapath
// Count table memory, accumulator, shift counter, index counter, config
// registers and the result register, driven by one control word a cycle.
// ----------------------------------------------------------------------------
module cftb_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cftb_pkg::ctrl_word_t  ctrl,
	output cftb_pkg::flags_t      flags,
	input  logic                  cmd_valid,
	input  cftb_pkg::action_t     cmd_action,
	input  logic [7:0]            cmd_slot,
	input  logic [31:0]           cmd_amount,
	input  logic                  cfg_valid,
	input  cftb_pkg::cfg_idx_t    cfg_index,
	input  logic [31:0]           cfg_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output cftb_pkg::status_t     rsp_status,
	output logic [31:0]           rsp_data
);

	// count table, entries never written read as zero
	cftb_pkg::count_t mem [cftb_pkg::TABLE_ENTRIES];
	logic [cftb_pkg::TABLE_ENTRIES-1:0] valid_q;
	cftb_pkg::count_t rdata_s1;
	logic             rvalid_s1;

	cftb_pkg::last_t   last_q;
	cftb_pkg::limit_t  limit_q;

	cftb_pkg::action_t action_q;
	logic [7:0]        slot_q;
	logic [31:0]       amount_q;

	cftb_pkg::sum_t    acc_q;
	cftb_pkg::shift_t  shift_q;
	cftb_pkg::idx_t    idx_q;
	cftb_pkg::count_t  prev_q;

	cftb_pkg::status_t res_status_q;
	cftb_pkg::data_t   res_data_q;
	logic              out_valid_q;
	cftb_pkg::status_t out_status_q;
	cftb_pkg::data_t   out_data_q;

	cftb_pkg::count_t  rdata;
	cftb_pkg::idx_t    slot_idx;
	cftb_pkg::idx_t    slot_next;
	cftb_pkg::idx_t    raddr;
	cftb_pkg::idx_t    waddr;
	cftb_pkg::count_t  wdata;
	logic              wr_en;
	cftb_pkg::count_t  scaled;
	cftb_pkg::count_t  cum_val;
	logic [cftb_pkg::COUNT_BITS:0] cum_sum;
	logic [cftb_pkg::COUNT_BITS:0] add_sum;
	logic              out_free;

	assign rdata     = rvalid_s1 ? rdata_s1 : '0;
	assign slot_idx  = cftb_pkg::idx_t'(slot_q);
	assign slot_next = cftb_pkg::idx_t'(slot_q + 8'd1);
	assign out_free  = !out_valid_q || rsp_ready;

	// flags for the sequencer
	always_comb begin
		flags.action   = action_q;
		flags.out_free = out_free;
		flags.idx_more = (idx_q != cftb_pkg::idx_t'(last_q));
		flags.limit_bad = ({25'd0, last_q} + 33'd1) >= {1'b0, limit_q};
		flags.fits = ({1'b0, acc_q} + 42'(last_q) + 42'd1) < 42'(limit_q);
		case (action_q)
			cftb_pkg::ACT_ADD:
				flags.bad_idx = ({1'b0, slot_q} + 9'd1) >= 9'(cftb_pkg::TABLE_ENTRIES);
			cftb_pkg::ACT_BUILD:
				flags.bad_idx = {1'b0, last_q} >= 9'(cftb_pkg::TABLE_ENTRIES);
			default:
				flags.bad_idx = {1'b0, slot_q} >= 9'(cftb_pkg::TABLE_ENTRIES);
		endcase
	end

	// saturating sums for add and cumulative passes
	always_comb begin
		scaled  = rdata >> shift_q;
		cum_sum = {1'b0, prev_q} + {1'b0, scaled} + 33'd1;
		add_sum = {1'b0, rdata} + {1'b0, amount_q};
		if (idx_q == '0) begin
			cum_val = scaled;
		end else begin
			cum_val = cum_sum[cftb_pkg::COUNT_BITS] ? '1 : cum_sum[cftb_pkg::COUNT_BITS-1:0];
		end
	end

	// memory port selection
	always_comb begin
		raddr = idx_q;
		wr_en = 1'b0;
		waddr = idx_q;
		wdata = cum_val;
		if (ctrl.uop == cftb_pkg::U_RD_SLOT) begin
			raddr = (action_q == cftb_pkg::ACT_ADD) ? slot_next : slot_idx;
		end
		case (ctrl.uop)
			cftb_pkg::U_WR_AMT: begin
				wr_en = 1'b1;
				waddr = slot_idx;
				wdata = amount_q;
			end
			cftb_pkg::U_ADD_WB: begin
				wr_en = 1'b1;
				waddr = slot_next;
				wdata = add_sum[cftb_pkg::COUNT_BITS] ? '1 : add_sum[cftb_pkg::COUNT_BITS-1:0];
			end
			cftb_pkg::U_CUM_WR: begin
				wr_en = 1'b1;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// control state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rvalid_s1   <= 1'b0;
			last_q      <= cftb_pkg::LAST_INDEX_RESET;
			limit_q     <= cftb_pkg::QUARTER_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= valid_q[raddr];
			if (wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cfg_valid) begin
				if (cfg_index == cftb_pkg::REG_LAST_INDEX) begin
					last_q <= cfg_data[cftb_pkg::LAST_BITS-1:0];
				end else if (cfg_index == cftb_pkg::REG_QUARTER_LIMIT) begin
					limit_q <= cfg_data;
				end
			end
			if (ctrl.uop == cftb_pkg::U_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.uop)
			cftb_pkg::U_LATCH: begin
				if (cmd_valid) begin
					action_q <= cmd_action;
					slot_q   <= cmd_slot;
					amount_q <= cmd_amount;
				end
			end
			cftb_pkg::U_WR_AMT, cftb_pkg::U_ADD_WB: begin
				res_status_q <= cftb_pkg::ST_OK;
				res_data_q   <= '0;
			end
			cftb_pkg::U_RES_RDATA: begin
				res_status_q <= cftb_pkg::ST_OK;
				res_data_q   <= rdata;
			end
			cftb_pkg::U_SUM_INIT: begin
				acc_q   <= '0;
				idx_q   <= '0;
				shift_q <= '0;
			end
			cftb_pkg::U_SUM_ACC: begin
				acc_q <= acc_q + cftb_pkg::SUM_BITS'(rdata);
				idx_q <= idx_q + 1'b1;
			end
			cftb_pkg::U_HALVE: begin
				acc_q   <= acc_q >> 1;
				shift_q <= shift_q + 1'b1;
			end
			cftb_pkg::U_IDX_CLR: begin
				idx_q <= '0;
			end
			cftb_pkg::U_CUM_WR: begin
				prev_q <= cum_val;
				idx_q  <= idx_q + 1'b1;
			end
			cftb_pkg::U_RES_PREV: begin
				res_status_q <= cftb_pkg::ST_OK;
				res_data_q   <= prev_q;
			end
			cftb_pkg::U_RES_ERR1: begin
				res_status_q <= cftb_pkg::ST_BAD_INDEX;
				res_data_q   <= '0;
			end
			cftb_pkg::U_RES_ERR2: begin
				res_status_q <= cftb_pkg::ST_UNREACHABLE;
				res_data_q   <= '0;
			end
			cftb_pkg::U_EMIT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_data_q   <= res_data_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_data   = out_data_q;

endmodule

// ===== sv/cumulative_frequency_table_builder_top.sv =====
// ----------------------------------------------------------------------------
// cumulative_frequency_table_builder_top
// Builds an arithmetic coder's cumulative frequency table in place.
// ----------------------------------------------------------------------------
// One request at a time runs through a microprogram over a table memory
// with one read port and one write port (registered read), so the memory
// port and the program length set the timing. A build sums the table
// entries up to L = last_index, halves the sum until it plus L+1 lies
// below the quarter limit and then forms the cumulative entries. The next
// request is taken once the result sits in the output register; a stalled
// result holds the block only when a second result is ready behind it.
// The register port is always ready; the user must write it only while no
// request is in flight, and the block itself does not enforce this.
module cumulative_frequency_table_builder_top (
	input logic        clk,
	input logic        arst_n,
	cftb_cmd_if.sink   cmd,
	cftb_rsp_if.source rsp,
	cftb_cfg_if.sink   cfg
);

	cftb_pkg::ctrl_word_t ctrl;
	cftb_pkg::flags_t     flags;

	assign cfg.ready = 1'b1;

	cftb_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.flags     (flags),
		.ctrl      (ctrl),
		.cmd_ready (cmd.ready)
	);

	cftb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.flags      (flags),
		.cmd_valid  (cmd.valid),
		.cmd_action (cmd.action),
		.cmd_slot   (cmd.slot),
		.cmd_amount (cmd.amount),
		.cfg_valid  (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_data   (rsp.data)
	);

endmodule

// ===== sv/cftb_checker.sv =====
// ----------------------------------------------------------------------------
// cftb_checker
// Port-level checks of the table builder, bound to its top level.
// ----------------------------------------------------------------------------
module cftb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input cftb_pkg::status_t rsp_status,
	input logic [31:0]       rsp_data
);

	logic       cmd_fire;
	logic       rsp_fire;
	logic [1:0] pend_q;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, cmd_fire} - {1'b0, rsp_fire};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_err_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != cftb_pkg::ST_OK |-> rsp_data == '0)
		else $error("error result with nonzero data");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> !cmd_ready)
		else $error("request taken while another is in work");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_fire |-> pend_q != 2'd0)
		else $error("result without a request");

endmodule

bind cumulative_frequency_table_builder_top cftb_checker u_cftb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_data   (rsp.data)
);
